@@ src/ghstat_pkg.sv @@
package ghstat_pkg;

  localparam int unsigned NUM_BINS_DEF    = 5;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_STATS = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_TOP   = 2'd2;
  localparam logic [1:0] CFG_TOTAL = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_MEDIAN = 2'd1;
  localparam logic [1:0] STAT_ZERO_DIV  = 2'd2;

  localparam logic [9:0]  BASE_RST  = 10'd450;
  localparam logic [7:0]  WIDTH_RST = 8'd60;
  localparam logic [9:0]  TOP_RST   = 10'd750;
  localparam logic [23:0] TOTAL_RST = 24'd5015752;

  localparam logic [9:0] OUT_MAX = 10'd1023;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MEAN_MUL,
    S_MEAN_CHK,
    S_MEAN_DIV,
    S_MODE_F0,
    S_MODE_F2,
    S_MODE_MUL,
    S_MODE_DIV,
    S_MED_SEL,
    S_MED_MUL,
    S_MED_DIV,
    S_STD_SQ,
    S_STD_MUL,
    S_STD_CHK,
    S_STD_DIV,
    S_SQRT,
    S_DONE
  } seq_state_e;

  function automatic logic [9:0] sat10(input logic [15:0] v);
    return (v > 16'(OUT_MAX)) ? OUT_MAX : v[9:0];
  endfunction

endpackage

@@ src/grouped_histogram_statistics.sv @@
// grouped histogram statistics
// command port: start_i with action_i and score_i is taken when busy_o is low.
// add-sample and clear beats leave busy_o low, so samples can be binned every
// cycle while busy_o is low. bin counts saturate at their maximum.
// a compute beat raises busy_o and runs a sequencer around one shared
// shift-add/subtract accumulator for serial multiplies and restoring divides,
// followed by a bit-at-a-time square root. the serial multiplies over
// midpoint bits (MID_W = midpoint width, 13 bits for the default five bins)
// and squared-deviation bits make up most of the run; it is shorter when the
// mean or deviation saturates, the mode divisor is zero or the median bin
// is not found or empty.
// the result shows on mean_o, mode_o, median_o, std_dev_o and status_o for
// exactly one cycle with valid_o high; there is no back pressure, the
// receiver must take it then. busy_o falls the cycle after.
// registers are written through cfg_we_i/cfg_idx_i/cfg_data_i at any edge;
// they should only change while busy_o is low.
// reset clears all bin counts, returns registers to their defaults and
// leaves the sequencer idle.
module grouped_histogram_statistics
  import ghstat_pkg::*;
#(
  parameter int unsigned NUM_BINS    = NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  score_i,
  output logic        valid_o,
  output logic [9:0]  mean_o,
  output logic [9:0]  mode_o,
  output logic [9:0]  median_o,
  output logic [9:0]  std_dev_o,
  output logic [1:0]  status_o
);

  localparam int CW     = COUNT_WIDTH;
  localparam int BIDX_W = $clog2(NUM_BINS);
  localparam int LO_W   = ((10 > BIDX_W + 8) ? 10 : BIDX_W + 8) + 1;
  localparam int MID_W  = LO_W + 1;
  localparam int MB_W   = 2 * MID_W;
  localparam int JW     = $clog2(MB_W);
  localparam int OPA_W  = (CW > 23) ? CW : 23;
  localparam int DEV_W  = 45;
  localparam int SUM_W  = CW + MID_W + BIDX_W;
  localparam int ACC_A  = (SUM_W > OPA_W + 9) ? SUM_W : OPA_W + 9;
  localparam int ACC_W  = (ACC_A > DEV_W) ? ACC_A : DEV_W;
  localparam int WIDE   = ((ACC_W > OPA_W + MB_W) ? ACC_W : OPA_W + MB_W) + 1;
  localparam int DVS_W  = (CW + 2 > 24) ? CW + 2 : 24;
  localparam int CUM_W  = (CW + BIDX_W > 24) ? CW + BIDX_W : 24;
  localparam logic [BIDX_W-1:0] LAST = BIDX_W'(NUM_BINS - 1);

  seq_state_e st_q, st_d;

  logic [9:0]  base_q;
  logic [7:0]  width_q;
  logic [9:0]  top_q;
  logic [23:0] total_q;

  logic [CW-1:0] cnt_q [NUM_BINS];
  logic [CW-1:0] cnt_d [NUM_BINS];

  logic [BIDX_W-1:0] idx_q, idx_d, m_q, m_d, med_q, med_d;
  logic [JW-1:0]     j_q, j_d;
  logic [4:0]        k_q, k_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [OPA_W-1:0]  opa_q, opa_d;
  logic [MB_W-1:0]   mb_q, mb_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [19:0]       q_q, q_d;
  logic [9:0]        r_q, r_d;
  logic [CW-1:0]     best_q, best_d, medcnt_q, medcnt_d, f0_q, f0_d;
  logic [CUM_W-1:0]  cum_q, cum_d, below_q, below_d;
  logic              found_q, found_d, zdiv_q, zdiv_d;
  logic [9:0]        mean_q, mean_d, mode_q, mode_d, median_q, median_d, sd_q, sd_d;

  function automatic logic [LO_W-1:0] lo_of(input logic [BIDX_W-1:0] b,
                                            input logic [9:0] base,
                                            input logic [7:0] w);
    return LO_W'(base) + LO_W'(b) * LO_W'(w);
  endfunction

  // binning lanes
  logic [NUM_BINS-1:0] hit;
  for (genvar g = 0; g < NUM_BINS; g++) begin : g_lane
    logic [LO_W-1:0] lo;
    logic [LO_W:0]   hi;
    assign lo = LO_W'(base_q) + LO_W'(g) * LO_W'(width_q);
    assign hi = (LO_W + 1)'(lo) + (LO_W + 1)'(width_q);
    if (g == NUM_BINS - 1) begin : g_last
      assign hit[g] = (LO_W'(score_i) >= lo) && (score_i <= top_q);
    end else begin : g_mid
      assign hit[g] = (width_q != 8'd0) && (LO_W'(score_i) >= lo) &&
                      ((LO_W + 1)'(score_i) < hi);
    end
  end

  // shared datapath terms
  logic [CW-1:0]    cnt_rd;
  logic [LO_W-1:0]  lo_idx, lo_m, lo_med;
  logic [MID_W-1:0] mid_c, mid_sh, dabs;
  logic [MB_W-1:0]  mb_sh, dd_c;
  logic             mbit;
  logic [OPA_W-1:0] opa_src;
  logic [WIDE-1:0]  addend, sum_w, dshift, dsub;
  logic             dev_ovf, dge;
  logic [19:0]      qbit, tt;
  logic [9:0]       t;
  logic [22:0]      half;
  logic [CUM_W-1:0] cum_n;
  logic [CW-1:0]    diff, f2_c;
  logic [CW:0]      div_c;
  logic             idx_last, k_zero, j_end_mean, j_end_8, j_end_std;
  logic             mean_sat, std_sat, div_zero, med_go;

  assign cnt_rd  = cnt_q[idx_q];
  assign lo_idx  = lo_of(idx_q, base_q, width_q);
  assign lo_m    = lo_of(m_q, base_q, width_q);
  assign lo_med  = lo_of(med_q, base_q, width_q);
  assign mid_c   = MID_W'(lo_idx) + MID_W'(width_q >> 1);
  assign mid_sh  = mid_c >> j_q;
  assign mb_sh   = mb_q >> j_q;
  assign mbit    = (st_q == S_MEAN_MUL) ? mid_sh[0] : mb_sh[0];
  assign opa_src = (st_q == S_MEAN_MUL) ? OPA_W'(cnt_rd) : opa_q;
  assign addend  = mbit ? (WIDE'(opa_src) << j_q) : '0;
  assign sum_w   = WIDE'(acc_q) + addend;
  assign dev_ovf = |sum_w[WIDE-1:DEV_W];
  assign dshift  = WIDE'(dvs_q) << k_q;
  assign dge     = WIDE'(acc_q) >= dshift;
  assign dsub    = WIDE'(acc_q) - dshift;
  assign qbit    = 20'(1) << k_q;
  assign t       = r_q | (10'(1) << k_q);
  assign tt      = {10'b0, t} * {10'b0, t};
  assign dabs    = (mid_c >= MID_W'(mean_q)) ? mid_c - MID_W'(mean_q)
                                             : MID_W'(mean_q) - mid_c;
  assign dd_c    = MB_W'(dabs) * MB_W'(dabs);
  assign half    = total_q[23:1];
  assign cum_n   = cum_q + CUM_W'(cnt_rd);
  assign diff    = best_q - f0_q;
  assign f2_c    = (m_q == LAST) ? '0 : cnt_rd;
  assign div_c   = (CW + 1)'(diff) + (CW + 1)'(best_q - f2_c);

  assign idx_last   = idx_q == LAST;
  assign k_zero     = k_q == 5'd0;
  assign j_end_mean = j_q == JW'(MID_W - 1);
  assign j_end_8    = j_q == JW'(7);
  assign j_end_std  = j_q == JW'(MB_W - 1);
  assign mean_sat   = (total_q == 24'd0) || (WIDE'(acc_q) >= (WIDE'(total_q) << 10));
  assign std_sat    = (total_q < 24'd2) ||
                      (WIDE'(acc_q) >= (WIDE'(total_q - 24'd1) << 20));
  assign div_zero   = div_c == '0;
  assign med_go     = found_q && (medcnt_q != '0);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:     if (start_i && action_i == ACT_STATS) st_d = S_MEAN_MUL;
      S_MEAN_MUL: if (j_end_mean && idx_last) st_d = S_MEAN_CHK;
      S_MEAN_CHK: st_d = mean_sat ? S_MODE_F0 : S_MEAN_DIV;
      S_MEAN_DIV: if (k_zero) st_d = S_MODE_F0;
      S_MODE_F0:  st_d = S_MODE_F2;
      S_MODE_F2:  st_d = div_zero ? S_MED_SEL : S_MODE_MUL;
      S_MODE_MUL: if (j_end_8) st_d = S_MODE_DIV;
      S_MODE_DIV: if (k_zero) st_d = S_MED_SEL;
      S_MED_SEL:  st_d = med_go ? S_MED_MUL : S_STD_SQ;
      S_MED_MUL:  if (j_end_8) st_d = S_MED_DIV;
      S_MED_DIV:  if (k_zero) st_d = S_STD_SQ;
      S_STD_SQ:   st_d = S_STD_MUL;
      S_STD_MUL:  if (j_end_std) st_d = idx_last ? S_STD_CHK : S_STD_SQ;
      S_STD_CHK:  st_d = std_sat ? S_DONE : S_STD_DIV;
      S_STD_DIV:  if (k_zero) st_d = S_SQRT;
      S_SQRT:     if (k_zero) st_d = S_DONE;
      S_DONE:     st_d = S_IDLE;
      default:    st_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    m_d      = m_q;
    med_d    = med_q;
    j_d      = j_q;
    k_d      = k_q;
    acc_d    = acc_q;
    opa_d    = opa_q;
    mb_d     = mb_q;
    dvs_d    = dvs_q;
    q_d      = q_q;
    r_d      = r_q;
    best_d   = best_q;
    medcnt_d = medcnt_q;
    f0_d     = f0_q;
    cum_d    = cum_q;
    below_d  = below_q;
    found_d  = found_q;
    zdiv_d   = zdiv_q;
    mean_d   = mean_q;
    mode_d   = mode_q;
    median_d = median_q;
    sd_d     = sd_q;

    // restoring divide step, used by the divide states
    if (st_q == S_MEAN_DIV || st_q == S_MODE_DIV || st_q == S_MED_DIV ||
        st_q == S_STD_DIV) begin
      if (dge) begin
        acc_d = dsub[ACC_W-1:0];
        q_d   = q_q | qbit;
      end
      if (!k_zero) k_d = k_q - 5'd1;
    end

    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          case (action_i)
            ACT_ADD: begin
              for (int i = 0; i < NUM_BINS; i++) begin
                if (hit[i] && cnt_q[i] != '1) cnt_d[i] = cnt_q[i] + CW'(1);
              end
            end
            ACT_CLEAR: begin
              for (int i = 0; i < NUM_BINS; i++) cnt_d[i] = '0;
            end
            ACT_STATS: begin
              acc_d   = '0;
              idx_d   = '0;
              j_d     = '0;
              cum_d   = '0;
              found_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_MEAN_MUL: begin
        acc_d = sum_w[ACC_W-1:0];
        if (j_q == '0) begin
          // first largest count, first bin reaching half
          if (idx_q == '0 || cnt_rd > best_q) begin
            best_d = cnt_rd;
            m_d    = idx_q;
          end
          if (!found_q) begin
            cum_d = cum_n;
            if (cum_n >= CUM_W'(half)) begin
              found_d  = 1'b1;
              med_d    = idx_q;
              below_d  = cum_q;
              medcnt_d = cnt_rd;
            end
          end
        end
        if (j_end_mean) begin
          j_d = '0;
          if (!idx_last) idx_d = idx_q + BIDX_W'(1);
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      S_MEAN_CHK: begin
        idx_d = m_q - BIDX_W'(1);
        if (mean_sat) begin
          mean_d = OUT_MAX;
        end else begin
          dvs_d = DVS_W'(total_q);
          k_d   = 5'd9;
          q_d   = '0;
        end
      end
      S_MEAN_DIV: begin
        if (k_zero) begin
          mean_d = q_d[9:0];
          idx_d  = m_q - BIDX_W'(1);
        end
      end
      S_MODE_F0: begin
        f0_d  = (m_q == '0) ? '0 : cnt_rd;
        idx_d = m_q + BIDX_W'(1);
      end
      S_MODE_F2: begin
        if (div_zero) begin
          mode_d = sat10(16'(lo_m));
          zdiv_d = 1'b1;
        end else begin
          zdiv_d = 1'b0;
          acc_d  = '0;
          j_d    = '0;
          opa_d  = OPA_W'(diff);
          mb_d   = MB_W'(width_q);
          dvs_d  = DVS_W'(div_c);
        end
      end
      S_MODE_MUL, S_MED_MUL: begin
        acc_d = sum_w[ACC_W-1:0];
        j_d   = j_q + JW'(1);
        if (j_end_8) begin
          k_d = 5'd7;
          q_d = '0;
        end
      end
      S_MODE_DIV: begin
        if (k_zero) mode_d = sat10(16'(lo_m) + 16'(q_d[7:0]));
      end
      S_MED_SEL: begin
        if (med_go) begin
          acc_d = '0;
          j_d   = '0;
          opa_d = OPA_W'(half - below_q[22:0]);
          mb_d  = MB_W'(width_q);
          dvs_d = DVS_W'(medcnt_q);
        end else begin
          median_d = found_q ? sat10(16'(lo_med)) : 10'd0;
          acc_d    = '0;
          idx_d    = '0;
        end
      end
      S_MED_DIV: begin
        if (k_zero) begin
          median_d = sat10(16'(lo_med) + 16'(q_d[7:0]));
          acc_d    = '0;
          idx_d    = '0;
        end
      end
      S_STD_SQ: begin
        mb_d  = dd_c;
        opa_d = OPA_W'(cnt_rd);
        j_d   = '0;
      end
      S_STD_MUL: begin
        // deviation sum sticks at its cap, which already forces full scale
        acc_d = dev_ovf ? ACC_W'({DEV_W{1'b1}}) : sum_w[ACC_W-1:0];
        if (j_end_std) begin
          if (!idx_last) idx_d = idx_q + BIDX_W'(1);
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      S_STD_CHK: begin
        if (std_sat) begin
          sd_d = OUT_MAX;
        end else begin
          dvs_d = DVS_W'(total_q - 24'd1);
          k_d   = 5'd19;
          q_d   = '0;
        end
      end
      S_STD_DIV: begin
        if (k_zero) begin
          r_d = '0;
          k_d = 5'd9;
        end
      end
      S_SQRT: begin
        if (tt <= q_q) r_d = t;
        if (k_zero) begin
          sd_d = (tt <= q_q) ? t : r_q;
        end else begin
          k_d = k_q - 5'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      base_q  <= BASE_RST;
      width_q <= WIDTH_RST;
      top_q   <= TOP_RST;
      total_q <= TOTAL_RST;
      for (int i = 0; i < NUM_BINS; i++) cnt_q[i] <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:  base_q  <= cfg_data_i[9:0];
          CFG_WIDTH: width_q <= cfg_data_i[7:0];
          CFG_TOP:   top_q   <= cfg_data_i[9:0];
          CFG_TOTAL: total_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    m_q      <= m_d;
    med_q    <= med_d;
    j_q      <= j_d;
    k_q      <= k_d;
    acc_q    <= acc_d;
    opa_q    <= opa_d;
    mb_q     <= mb_d;
    dvs_q    <= dvs_d;
    q_q      <= q_d;
    r_q      <= r_d;
    best_q   <= best_d;
    medcnt_q <= medcnt_d;
    f0_q     <= f0_d;
    cum_q    <= cum_d;
    below_q  <= below_d;
    found_q  <= found_d;
    zdiv_q   <= zdiv_d;
    mean_q   <= mean_d;
    mode_q   <= mode_d;
    median_q <= median_d;
    sd_q     <= sd_d;
  end

  assign busy_o    = st_q != S_IDLE;
  assign valid_o   = st_q == S_DONE;
  assign mean_o    = mean_q;
  assign mode_o    = mode_q;
  assign median_o  = median_q;
  assign std_dev_o = sd_q;
  assign status_o  = !found_q ? STAT_NO_MEDIAN : (zdiv_q ? STAT_ZERO_DIV : STAT_OK);

  a_stats_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && action_i == ACT_STATS |=> busy_o && !valid_o)
    else $error("compute beat did not start the sequencer");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o && !valid_o)
    else $error("result strobe not followed by idle");

  a_no_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_NO_MEDIAN |-> median_o == 10'd0)
    else $error("median not zero when half point unreached");

  a_other_beats_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && action_i != ACT_STATS |=> !busy_o)
    else $error("add or clear beat made the block busy");

endmodule
